/* design/nmea_sentence_checksum_deframer_top_macros.svh */
// ---------------------------------------------------------------------------
// NMEA checksum deframer assertion macros
// Concurrent assertion wrappers shared by the deframer RTL files.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_DEFRAMER_TOP_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define NMEA_CK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("nmea_ck assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NMEA_CK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nmea_ck next-cycle assertion failed");

`else

`define NMEA_CK_ASSERT(lbl, clk, rstn, prop)
`define NMEA_CK_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* design/nmea_ck_pkg.sv */
// ---------------------------------------------------------------------------
// NMEA checksum deframer package
// Character constants, result codes and the hex digit decode.
// ---------------------------------------------------------------------------
`default_nettype none

package nmea_ck_pkg;

  localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
  localparam logic [7:0] CHAR_STAR       = 8'h2A;
  localparam logic [7:0] HEX_ALPHA_LIMIT = 8'd64;
  localparam logic [8:0] ALPHA_OFFSET    = 9'd55;
  localparam logic [8:0] DIGIT_OFFSET    = 9'd48;
  localparam int unsigned HEX_SHIFT      = 4;   // times 16
  localparam logic [7:0] BUF_LEN_RESET   = 8'd128;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_MATCH    = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_buffer;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       end_of_sentence;
  } result_t;

  // Letters above '@' decode with the alpha offset, everything else as a digit.
  function automatic logic signed [8:0] hex_value(input logic [7:0] c);
    logic [8:0] ext;
    ext = {1'b0, c};
    return (c > HEX_ALPHA_LIMIT) ? $signed(ext - ALPHA_OFFSET)
                                 : $signed(ext - DIGIT_OFFSET);
  endfunction

endpackage

`default_nettype wire

/* design/nmea_ck_ifs.sv */
// ---------------------------------------------------------------------------
// NMEA checksum deframer channels
// Valid/ready channels for received bytes and for deframed results.
// ---------------------------------------------------------------------------
`default_nettype none

interface nmea_ck_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_buffer;

  modport source (output valid, output in_byte, output first_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input first_of_buffer, output ready);
endinterface

interface nmea_ck_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       end_of_sentence;

  modport source (output valid, output out_byte, output kind, output end_of_sentence,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input end_of_sentence,
                  output ready);
endinterface

`default_nettype wire

/* design/nmea_ck_core.sv */
// ---------------------------------------------------------------------------
// NMEA checksum deframer core
// Sentence state machine: hunt, body XOR, hex check and verdict per byte.
// ---------------------------------------------------------------------------
`default_nettype none
`include "nmea_sentence_checksum_deframer_top_macros.svh"

module nmea_ck_core
  import nmea_ck_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire item_t      item_i,
  input  wire logic [7:0] buf_len_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_BODY,
    PH_HEX1,
    PH_HEX2,
    PH_IDLE
  } phase_e;

  phase_e            phase_q, phase_d, phase_w;
  logic [7:0]        sum_q, sum_d, sum_w;
  logic [7:0]        cnt_q, cnt_d, cnt_w, cnt_inc;
  logic signed [8:0] hi_q, hi_d, hi_w;
  logic signed [13:0] check;

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'd0, kind: KIND_PAYLOAD, end_of_sentence: 1'b0};
    phase_w     = phase_q;
    sum_w       = sum_q;
    cnt_w       = cnt_q;
    hi_w        = hi_q;

    // A new buffer cuts off any open sentence, then restarts the hunt.
    if (item_i.first_of_buffer) begin
      if (phase_q == PH_BODY || phase_q == PH_HEX1 || phase_q == PH_HEX2) begin
        res_valid_o = 1'b1;
        res_o       = '{out_byte: 8'd0, kind: KIND_TRUNC, end_of_sentence: 1'b1};
      end
      phase_w = PH_HUNT;
      sum_w   = 8'd0;
      cnt_w   = 8'd0;
      hi_w    = 9'sd0;
    end

    phase_d = phase_w;
    sum_d   = sum_w;
    cnt_d   = cnt_w;
    hi_d    = hi_w;
    cnt_inc = cnt_w + 8'd1;
    check   = 14'($signed({hi_w, 4'b0000})) + 14'(hex_value(item_i.in_byte));

    case (phase_w)
      PH_HUNT: begin
        if (item_i.in_byte == CHAR_DOLLAR) begin
          phase_d = (cnt_w < buf_len_i) ? PH_BODY : PH_IDLE;
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc == buf_len_i) begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_BODY: begin
        if (item_i.in_byte == CHAR_STAR) begin
          phase_d = PH_HEX1;
        end else begin
          cnt_d = cnt_inc;
          res_valid_o = 1'b1;
          if (cnt_inc == buf_len_i) begin
            phase_d = PH_IDLE;
            res_o   = '{out_byte: 8'd0, kind: KIND_TRUNC, end_of_sentence: 1'b1};
          end else begin
            sum_d = sum_w ^ item_i.in_byte;
            res_o = '{out_byte: item_i.in_byte, kind: KIND_PAYLOAD, end_of_sentence: 1'b0};
          end
        end
      end
      PH_HEX1: begin
        hi_d    = hex_value(item_i.in_byte);
        phase_d = PH_HEX2;
      end
      PH_HEX2: begin
        phase_d     = PH_IDLE;
        res_valid_o = 1'b1;
        res_o       = '{out_byte: 8'd0,
                        kind: (check == $signed({6'd0, sum_w})) ? KIND_MATCH : KIND_MISMATCH,
                        end_of_sentence: 1'b1};
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= 8'd0;
      cnt_q   <= 8'd0;
      hi_q    <= 9'sd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
    end
  end

  `NMEA_CK_ASSERT_NEXT(a_verdict_goes_idle, clk_i, rst_ni,
    fire_i && res_valid_o && (res_o.kind == KIND_MATCH || res_o.kind == KIND_MISMATCH),
    phase_q == PH_IDLE)
  `NMEA_CK_ASSERT(a_idle_is_silent, clk_i, rst_ni,
    !(phase_q == PH_IDLE && !item_i.first_of_buffer && res_valid_o))

endmodule

`default_nettype wire

/* design/nmea_sentence_checksum_deframer_top.sv */
// ---------------------------------------------------------------------------
// NMEA sentence checksum deframer
// Extracts sentence bodies from received bytes and checks the hex checksum.
// ---------------------------------------------------------------------------
//
//   channel   direction  payload                          transfer when
//   in_i      sink       in_byte, first_of_buffer          valid & ready
//   out_o     source     out_byte, kind, end_of_sentence   valid & ready
//   cfg       write      cfg_wdata_i (buffer length)       cfg_we_i
//
// One byte per cycle while out_o is not stalled; a taken byte passes through
// the input register and then the result register before any result from it
// is valid.
// Reset returns to the hunt for '$' with a buffer length of 128.
// A stalled result holds in the result register; the input register keeps
// taking bytes until both registers are full.
//
`default_nettype none
`include "nmea_sentence_checksum_deframer_top_macros.svh"

module nmea_sentence_checksum_deframer_top
  import nmea_ck_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  nmea_ck_byte_if.sink    in_i,
  nmea_ck_res_if.source   out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [7:0] buf_len_q;
  logic       s1_valid_q;
  item_t      s1_item_q;
  logic       out_valid_q;
  result_t    res_q;

  logic       s2_free;
  logic       advance;
  logic       core_valid;
  result_t    core_res;

  assign s2_free     = !out_valid_q || out_o.ready;
  assign advance     = s1_valid_q && s2_free;
  assign in_i.ready  = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= BUF_LEN_RESET;
    end else if (cfg_we_i) begin
      buf_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= '{in_byte: in_i.in_byte, first_of_buffer: in_i.first_of_buffer};
    end
  end

  nmea_ck_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (s1_item_q),
    .buf_len_i   (buf_len_q),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= advance && core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = res_q.out_byte;
  assign out_o.kind            = res_q.kind;
  assign out_o.end_of_sentence = res_q.end_of_sentence;

  `NMEA_CK_ASSERT(a_stall_needs_full, clk_i, rst_ni,
    in_i.ready || (s1_valid_q && out_valid_q && !out_o.ready))
  `NMEA_CK_ASSERT_NEXT(a_take_fills_s1, clk_i, rst_ni,
    in_i.valid && in_i.ready, s1_valid_q)
  `NMEA_CK_ASSERT(a_verdict_flag, clk_i, rst_ni,
    !out_valid_q || ((res_q.kind == KIND_PAYLOAD) != res_q.end_of_sentence))

endmodule

`default_nettype wire
